// ----- src/jsu_pkg.sv -----
// Shared types, codes and constants of the JSON string unescaper.
package jsu_pkg;

  localparam int unsigned IN_QUEUE_DEPTH  = 4;
  localparam int unsigned OUT_QUEUE_DEPTH = 4;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESC    = 2'd1;
  localparam logic [1:0] MODE_HEX    = 2'd2;

  localparam logic [2:0] CLS_PLAIN  = 3'd0;
  localparam logic [2:0] CLS_BSLASH = 3'd1;
  localparam logic [2:0] CLS_U      = 3'd2;
  localparam logic [2:0] CLS_N      = 3'd3;
  localparam logic [2:0] CLS_R      = 3'd4;
  localparam logic [2:0] CLS_T      = 3'd5;
  localparam logic [2:0] CLS_SELF   = 3'd6;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

  typedef struct packed {
    logic [7:0] ch;
    logic [2:0] cls;
    logic       hex;
    logic [3:0] nib;
  } chr_t;

  typedef struct packed {
    chr_t c;
    logic last;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage

// ----- src/jsu_fifo.sv -----
// Small first-in first-out queue of register slots.
module jsu_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = jsu_pkg::IN_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- src/jsu_front.sv -----
// Front end: classify each input byte and queue it for the back end.
module jsu_front #(
  parameter int unsigned DEPTH = jsu_pkg::IN_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [7:0]          in_char,
  input  logic                in_last,
  output logic                full,
  output logic                it_valid,
  output jsu_pkg::item_t      it,
  input  logic                it_pop
);

  jsu_pkg::item_t                   cls_item;
  logic [$bits(jsu_pkg::item_t)-1:0] q_dout;
  logic                             q_empty;
  logic [7:0]                       nib_full;
  logic                             is_dig, is_lo, is_up;

  always_comb begin
    is_dig = (in_char >= 8'h30) && (in_char <= 8'h39);
    is_lo  = (in_char >= 8'h61) && (in_char <= 8'h66);
    is_up  = (in_char >= 8'h41) && (in_char <= 8'h46);
    if (is_dig) begin
      nib_full = in_char - 8'h30;
    end else if (is_lo) begin
      nib_full = in_char - 8'h57;
    end else begin
      nib_full = in_char - 8'h37;
    end
    cls_item.c.ch  = in_char;
    cls_item.c.hex = is_dig | is_lo | is_up;
    cls_item.c.nib = nib_full[3:0];
    cls_item.last  = in_last;
    unique case (in_char) inside
      jsu_pkg::CH_BSLASH: cls_item.c.cls = jsu_pkg::CLS_BSLASH;
      jsu_pkg::CH_U:      cls_item.c.cls = jsu_pkg::CLS_U;
      jsu_pkg::CH_N:      cls_item.c.cls = jsu_pkg::CLS_N;
      jsu_pkg::CH_R:      cls_item.c.cls = jsu_pkg::CLS_R;
      jsu_pkg::CH_T:      cls_item.c.cls = jsu_pkg::CLS_T;
      jsu_pkg::CH_QUOTE,
      jsu_pkg::CH_SLASH:  cls_item.c.cls = jsu_pkg::CLS_SELF;
      default:            cls_item.c.cls = jsu_pkg::CLS_PLAIN;
    endcase
  end

  jsu_fifo #(
    .WIDTH($bits(jsu_pkg::item_t)),
    .DEPTH(DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .din  (cls_item),
    .full (full),
    .pop  (it_pop),
    .dout (q_dout),
    .empty(q_empty)
  );

  assign it       = jsu_pkg::item_t'(q_dout);
  assign it_valid = ~q_empty;

endmodule

// ----- src/jsu_back.sv -----
// Back end: escape state machine, replay of failed hex runs and byte emission.
module jsu_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           it_valid,
  input  jsu_pkg::item_t it,
  output logic           it_pop,
  input  logic           oq_full,
  output logic           res_push,
  output jsu_pkg::res_t  res
);

  logic [1:0]    mode_r, mode_nxt;
  logic [1:0]    hcnt_r, hcnt_nxt;
  jsu_pkg::chr_t held_r [3];
  jsu_pkg::chr_t rp_r [4];
  logic [2:0]    rpcnt_r, rpcnt_nxt;
  logic [7:0]    ebuf_r [5];
  logic [2:0]    ecnt_r, ecnt_nxt;
  logic          fin_r, fin_nxt;
  logic          flush_r, flush_nxt;
  logic          slast_r, slast_nxt;
  logic [7:0]    lag_r;
  logic          lagv_r, lagv_nxt;

  logic          go, sel_e, sel_rp, sel_fin, sel_fl, sel_in, do_feed, lagging;
  jsu_pkg::chr_t fc;
  logic [1:0]    f_n;
  logic [7:0]    f_b [3];
  logic [1:0]    f_mode, f_hcnt;
  logic          f_wr, f_replay, hex_ok;
  logic [15:0]   cp;
  logic [2:0]    fin_n;
  logic          emit_v;
  logic [7:0]    emit_b;

  assign go      = ~oq_full;
  assign sel_e   = (ecnt_r != '0);
  assign sel_rp  = !sel_e && (rpcnt_r != '0);
  assign sel_fin = !sel_e && (rpcnt_r == '0) && fin_r;
  assign sel_fl  = !sel_e && (rpcnt_r == '0) && !fin_r && flush_r;
  assign sel_in  = !sel_e && (rpcnt_r == '0) && !fin_r && !flush_r && it_valid;
  assign do_feed = sel_rp | sel_in;
  assign fc      = sel_rp ? rp_r[0] : it.c;
  assign it_pop  = go & sel_in;
  assign lagging = slast_r | (sel_in & it.last);

  assign hex_ok = held_r[0].hex & held_r[1].hex & held_r[2].hex & fc.hex;
  assign cp     = {held_r[0].nib, held_r[1].nib, held_r[2].nib, fc.nib};

  // Process one byte through the escape rules.
  always_comb begin
    f_n      = 2'd0;
    f_b[0]   = fc.ch;
    f_b[1]   = fc.ch;
    f_b[2]   = fc.ch;
    f_mode   = jsu_pkg::MODE_NORMAL;
    f_hcnt   = hcnt_r;
    f_wr     = 1'b0;
    f_replay = 1'b0;
    unique case (mode_r)
      jsu_pkg::MODE_ESC: begin
        unique case (fc.cls) inside
          jsu_pkg::CLS_U: begin
            f_mode = jsu_pkg::MODE_HEX;
            f_hcnt = 2'd0;
          end
          jsu_pkg::CLS_N: begin
            f_n    = 2'd1;
            f_b[0] = jsu_pkg::CH_LF;
          end
          jsu_pkg::CLS_R: begin
            f_n    = 2'd1;
            f_b[0] = jsu_pkg::CH_CR;
          end
          jsu_pkg::CLS_T: begin
            f_n    = 2'd1;
            f_b[0] = jsu_pkg::CH_TAB;
          end
          jsu_pkg::CLS_BSLASH, jsu_pkg::CLS_SELF: begin
            f_n = 2'd1;
          end
          default: begin
            f_n    = 2'd2;
            f_b[0] = jsu_pkg::CH_BSLASH;
          end
        endcase
      end
      jsu_pkg::MODE_HEX: begin
        if (hcnt_r != 2'd3) begin
          f_mode = jsu_pkg::MODE_HEX;
          f_wr   = 1'b1;
          f_hcnt = hcnt_r + 1'b1;
        end else begin
          f_hcnt = 2'd0;
          if (!hex_ok) begin
            f_replay = 1'b1;
          end else if (cp <= 16'h007F) begin
            f_n    = 2'd1;
            f_b[0] = {1'b0, cp[6:0]};
          end else if (cp <= 16'h07FF) begin
            f_n    = 2'd2;
            f_b[0] = jsu_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]};
            f_b[1] = jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]};
          end else begin
            f_n    = 2'd3;
            f_b[0] = jsu_pkg::UTF8_LEAD3 | {4'b0000, cp[15:12]};
            f_b[1] = jsu_pkg::UTF8_CONT | {2'b00, cp[11:6]};
            f_b[2] = jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]};
          end
        end
      end
      default: begin
        if (fc.cls == jsu_pkg::CLS_BSLASH) begin
          f_mode = jsu_pkg::MODE_ESC;
        end else begin
          f_n = 2'd1;
        end
      end
    endcase
  end

  always_comb begin
    unique case (mode_r)
      jsu_pkg::MODE_ESC: fin_n = 3'd1;
      jsu_pkg::MODE_HEX: fin_n = 3'd2 + {1'b0, hcnt_r};
      default:           fin_n = 3'd0;
    endcase
  end

  always_comb begin
    emit_v = 1'b0;
    emit_b = ebuf_r[0];
    if (sel_e) begin
      emit_v = 1'b1;
    end else if (do_feed && (f_n != 2'd0)) begin
      emit_v = 1'b1;
      emit_b = f_b[0];
    end
  end

  // Hold the bytes of a final string step one behind, so the last can be marked.
  always_comb begin
    res_push  = 1'b0;
    res.data  = lag_r;
    res.last  = 1'b0;
    lagv_nxt  = lagv_r;
    slast_nxt = slast_r;
    flush_nxt = flush_r;
    fin_nxt   = fin_r;
    mode_nxt  = mode_r;
    hcnt_nxt  = hcnt_r;
    rpcnt_nxt = rpcnt_r;
    ecnt_nxt  = ecnt_r;
    if (go) begin
      if (emit_v) begin
        if (lagging) begin
          res_push = lagv_r;
          lagv_nxt = 1'b1;
        end else begin
          res_push = 1'b1;
          res.data = emit_b;
        end
      end
      if (sel_e) begin
        ecnt_nxt = ecnt_r - 1'b1;
      end
      if (do_feed) begin
        mode_nxt = f_mode;
        hcnt_nxt = f_hcnt;
        ecnt_nxt = (f_n == 2'd0) ? 3'd0 : {1'b0, f_n - 2'd1};
        if (sel_rp) begin
          rpcnt_nxt = rpcnt_r - 1'b1;
        end
        if (f_replay) begin
          rpcnt_nxt = 3'd4;
        end
      end
      if (sel_in && it.last) begin
        fin_nxt   = 1'b1;
        slast_nxt = 1'b1;
      end
      if (sel_fin) begin
        ecnt_nxt  = fin_n;
        mode_nxt  = jsu_pkg::MODE_NORMAL;
        hcnt_nxt  = 2'd0;
        fin_nxt   = 1'b0;
        flush_nxt = 1'b1;
      end
      if (sel_fl) begin
        res_push  = lagv_r;
        res.last  = 1'b1;
        lagv_nxt  = 1'b0;
        flush_nxt = 1'b0;
        slast_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= jsu_pkg::MODE_NORMAL;
      hcnt_r  <= '0;
      rpcnt_r <= '0;
      ecnt_r  <= '0;
      fin_r   <= 1'b0;
      flush_r <= 1'b0;
      slast_r <= 1'b0;
      lagv_r  <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      hcnt_r  <= hcnt_nxt;
      rpcnt_r <= rpcnt_nxt;
      ecnt_r  <= ecnt_nxt;
      fin_r   <= fin_nxt;
      flush_r <= flush_nxt;
      slast_r <= slast_nxt;
      lagv_r  <= lagv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      if (emit_v && lagging) begin
        lag_r <= emit_b;
      end
      if (do_feed && f_wr) begin
        held_r[hcnt_r] <= fc;
      end
      if (sel_e) begin
        for (int i = 0; i < 4; i++) begin
          ebuf_r[i] <= ebuf_r[i+1];
        end
      end else if (do_feed) begin
        ebuf_r[0] <= f_b[1];
        ebuf_r[1] <= f_b[2];
      end else if (sel_fin) begin
        ebuf_r[0] <= (mode_r == jsu_pkg::MODE_ESC) ? jsu_pkg::CH_BSLASH : jsu_pkg::CH_BSLASH;
        ebuf_r[1] <= jsu_pkg::CH_U;
        ebuf_r[2] <= held_r[0].ch;
        ebuf_r[3] <= held_r[1].ch;
        ebuf_r[4] <= held_r[2].ch;
      end
      if (do_feed && f_replay) begin
        rp_r[0] <= held_r[0];
        rp_r[1] <= held_r[1];
        rp_r[2] <= held_r[2];
        rp_r[3] <= fc;
      end else if (sel_rp) begin
        for (int i = 0; i < 3; i++) begin
          rp_r[i] <= rp_r[i+1];
        end
      end
    end
  end

endmodule

// ----- src/json_string_unescape_core.sv -----
// Top level of the streaming JSON string unescaper.
//
//  channel  ports                     handshake
//  input    in_char, in_last          beat when push & !full
//  result   out_byte, out_last        beat when pop & !empty
//
// Plain text streams at one beat per cycle while the result queue has room.
// Result bytes past the first of a step (unknown escape, multi-byte UTF-8,
// replayed byte) hold the input, a failed \u run replays its four held bytes,
// and the end of a string emits the literal bytes of a cut-short escape before
// its last byte is marked. Reset clears both queues and the escape state. A full
// result queue stops the back end; the input queue takes beats until it fills.
module json_string_unescape_core #(
  parameter int unsigned IN_DEPTH  = jsu_pkg::IN_QUEUE_DEPTH,
  parameter int unsigned OUT_DEPTH = jsu_pkg::OUT_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       full,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic                              it_valid, it_pop, oq_full, res_push;
  jsu_pkg::item_t                    it;
  jsu_pkg::res_t                     res, oq_res;
  logic [$bits(jsu_pkg::res_t)-1:0]  oq_dout;

  jsu_front #(
    .DEPTH(IN_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_char (in_char),
    .in_last (in_last),
    .full    (full),
    .it_valid(it_valid),
    .it      (it),
    .it_pop  (it_pop)
  );

  jsu_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .it_valid(it_valid),
    .it      (it),
    .it_pop  (it_pop),
    .oq_full (oq_full),
    .res_push(res_push),
    .res     (res)
  );

  jsu_fifo #(
    .WIDTH($bits(jsu_pkg::res_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .din  (res),
    .full (oq_full),
    .pop  (pop),
    .dout (oq_dout),
    .empty(empty)
  );

  assign oq_res   = jsu_pkg::res_t'(oq_dout);
  assign out_byte = oq_res.data;
  assign out_last = oq_res.last;

endmodule

// ----- dv/json_string_unescape_core_tb.sv -----
// Self-checking testbench for json_string_unescape_core: directed, random and stall tests.
module json_string_unescape_core_tb;
  import jsu_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_BEAT_OUT = 8;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic [7:0] in_char = 8'h00;
  logic       in_last = 1'b0;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       out_last;

  // unescaper state mirror
  logic [1:0] esc_mode = MODE_NORMAL;
  logic [2:0] held_cnt = 3'd0;
  logic [7:0] held_chars [4];

  res_t        pending_bytes [$];
  int unsigned miss_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          gaps_on = 1'b1;
  bit          calm = 1'b0;
  bit          hold_pop = 1'b0;
  bit          push_hi = 1'b0;

  json_string_unescape_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_char (in_char),
    .in_last (in_last),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .out_byte(out_byte),
    .out_last(out_last)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("json_string_unescape_core verification failed");
      $finish;
    end
  end

  // {valid, nibble}
  function automatic logic [4:0] hex_nib(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 10)};
    return 5'd0;
  endfunction

  function automatic void unescape_byte(input logic [7:0] c, input logic last);
    logic [7:0]  work [$];
    logic [7:0]  outs [$];
    logic [7:0]  copy [4];
    logic [7:0]  ch;
    logic [4:0]  hv;
    logic [15:0] cp;
    logic [2:0]  n;
    bit          ok;
    res_t        r;
    work = {work, c};
    while (work.size() > 0) begin
      ch = work.pop_front();
      case (esc_mode)
        MODE_ESC: begin
          esc_mode = MODE_NORMAL;
          if (ch == CH_U) begin
            esc_mode = MODE_HEX;
            held_cnt = 3'd0;
          end else if (ch == CH_N) begin
            outs = {outs, CH_LF};
          end else if (ch == CH_R) begin
            outs = {outs, CH_CR};
          end else if (ch == CH_T) begin
            outs = {outs, CH_TAB};
          end else if (ch == CH_QUOTE || ch == CH_BSLASH || ch == CH_SLASH) begin
            outs = {outs, ch};
          end else begin
            outs = {outs, CH_BSLASH};
            outs = {outs, ch};
          end
        end
        MODE_HEX: begin
          held_chars[held_cnt[1:0]] = ch;
          held_cnt = held_cnt + 3'd1;
          if (held_cnt >= 3'd4) begin
            esc_mode = MODE_NORMAL;
            held_cnt = 3'd0;
            ok = 1'b1;
            cp = 16'h0000;
            for (int i = 0; i < 4; i++) begin
              copy[i] = held_chars[i];
              hv = hex_nib(held_chars[i]);
              if (!hv[4]) ok = 1'b0;
              else cp = {cp[11:0], hv[3:0]};
            end
            if (ok) begin
              if (cp <= 16'h007F) begin
                outs = {outs, cp[7:0]};
              end else if (cp <= 16'h07FF) begin
                outs = {outs, UTF8_LEAD2 | {3'b000, cp[10:6]}};
                outs = {outs, UTF8_CONT | {2'b00, cp[5:0]}};
              end else begin
                outs = {outs, UTF8_LEAD3 | {4'h0, cp[15:12]}};
                outs = {outs, UTF8_CONT | {2'b00, cp[11:6]}};
                outs = {outs, UTF8_CONT | {2'b00, cp[5:0]}};
              end
            end else begin
              for (int i = 3; i >= 0; i--) work.push_front(copy[i]);
            end
          end
        end
        default: begin
          esc_mode = MODE_NORMAL;
          if (ch == CH_BSLASH) esc_mode = MODE_ESC;
          else outs = {outs, ch};
        end
      endcase
    end
    if (last) begin
      if (esc_mode == MODE_ESC) begin
        outs = {outs, CH_BSLASH};
      end else if (esc_mode == MODE_HEX) begin
        n = (held_cnt > 3'd4) ? 3'd4 : held_cnt;
        outs = {outs, CH_BSLASH};
        outs = {outs, CH_U};
        for (int i = 0; i < n; i++) outs = {outs, held_chars[i]};
      end
      esc_mode = MODE_NORMAL;
      held_cnt = 3'd0;
    end
    if (outs.size() > MAX_BEAT_OUT) outs = outs[0:MAX_BEAT_OUT-1];
    foreach (outs[i]) begin
      r.data = outs[i];
      r.last = last && (i == outs.size() - 1);
      pending_bytes = {pending_bytes, r};
    end
  endfunction

  function automatic void note_miss(input string what, input res_t want);
    miss_cnt++;
    if (miss_cnt <= 10)
      $display("%s: expected byte %02h last %0b, got byte %02h last %0b",
               what, want.data, want.last, out_byte, out_last);
  endfunction

  // result side: check each beat, then pick pop for the next cycle
  initial begin : result_side
    int   stall_left;
    res_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && empty === 1'b0) begin
        if (pending_bytes.size() == 0) begin
          want = '0;
          note_miss("unexpected beat", want);
        end else begin
          want = pending_bytes.pop_front();
          if (out_byte !== want.data || out_last !== want.last)
            note_miss("mismatch", want);
        end
      end
      if (hold_pop) begin
        hold_pop = 1'b0;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_beat(input logic [7:0] c, input logic l);
    push <= 1'b1;
    in_char <= c;
    in_last <= l;
    push_hi = 1'b1;
    do @(posedge clk); while (full !== 1'b0);
    unescape_byte(c, l);
    sent_cnt++;
    if (gaps_on && !calm && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      push_hi = 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic stop_push();
    if (push_hi) begin
      push <= 1'b0;
      push_hi = 1'b0;
    end
  endtask

  task automatic send_text(input logic [7:0] body [$]);
    foreach (body[i]) send_beat(body[i], i == body.size() - 1);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit up);
    if (v < 4'd10) return 8'("0" + v);
    return up ? 8'("A" + v - 10) : 8'("a" + v - 10);
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_nib(c) != 5'd0);
    return c;
  endfunction

  function automatic logic [15:0] pick_code_point();
    logic [15:0] edges [8];
    edges = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD800, 16'hDFFF,
              16'hFFFF};
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 16'h007F));
      1: return 16'($urandom_range(16'h0080, 16'h07FF));
      2: return 16'($urandom_range(16'h0800, 16'hFFFF));
      default: return edges[$urandom_range(0, 7)];
    endcase
  endfunction

  task automatic send_random_string();
    logic [7:0]  body [$];
    logic [7:0]  simple [7];
    logic [15:0] cp;
    int          bad;
    simple = '{CH_N, CH_R, CH_T, CH_QUOTE, CH_BSLASH, CH_SLASH, 8'h00};
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 9)) inside
        0, 1, 2: body = {body, 8'($urandom_range(0, 255))};
        3, 4: begin
          simple[6] = 8'($urandom_range(0, 255));
          body = {body, CH_BSLASH};
          body = {body, simple[$urandom_range(0, 6)]};
        end
        5, 6, 7: begin
          cp = pick_code_point();
          body = {body, CH_BSLASH};
          body = {body, CH_U};
          for (int i = 3; i >= 0; i--)
            body = {body, hex_char(cp[i*4 +: 4], $urandom_range(0, 1))};
        end
        8: begin
          bad = $urandom_range(0, 3);
          body = {body, CH_BSLASH};
          body = {body, CH_U};
          for (int i = 0; i < 4; i++) begin
            if (i == bad) body = {body, non_hex_char()};
            else if ($urandom_range(0, 5) == 0)
              body = {body, ($urandom_range(0, 1) ? CH_BSLASH : CH_U)};
            else body = {body, hex_char(4'($urandom_range(0, 15)), $urandom_range(0, 1))};
          end
        end
        default: begin
          body = {body, CH_BSLASH};
          if ($urandom_range(0, 1)) begin
            body = {body, CH_U};
            repeat ($urandom_range(0, 3))
              body = {body, hex_char(4'($urandom_range(0, 15)), $urandom_range(0, 1))};
          end
        end
      endcase
    end
    send_text(body);
  endtask

  task automatic test_escapes();
    send_text('{8'h00, CH_BSLASH, CH_N, CH_BSLASH, CH_R, CH_BSLASH, CH_T,
                CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_BSLASH, CH_BSLASH, CH_SLASH,
                CH_BSLASH, 8'hFF});
  endtask

  task automatic test_unicode();
    // surrogate three-byte form, then the two-byte upper edge
    send_text('{CH_BSLASH, CH_U, "D", "8", "3", "f", CH_BSLASH, CH_U, "0", "7", "F", "f"});
    // failed run replays into a new escape that the end of string cuts short
    send_text('{CH_BSLASH, CH_U, "1", CH_BSLASH, CH_U, "0"});
    // lone backslash at the end
    send_text('{CH_BSLASH});
  endtask

  task automatic test_backpressure();
    int unsigned stop_at;
    stop_at = sent_cnt + 40;
    gaps_on = 1'b0;
    hold_pop = 1'b1;
    while (sent_cnt < stop_at) send_random_string();
    gaps_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    stop_push();
    wait (pending_bytes.size() == 0);
    @(posedge clk);
  endtask

  task automatic test_random(input int unsigned beats);
    int unsigned stop_at;
    stop_at = sent_cnt + beats;
    while (sent_cnt < stop_at) send_random_string();
  endtask

  task automatic test_calm_tail();
    int unsigned stop_at;
    stop_at = sent_cnt + 50;
    calm = 1'b1;
    while (sent_cnt < stop_at) send_random_string();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_escapes();
    test_unicode();
    test_backpressure();
    test_random(110);
    test_drain_pause();
    test_random(110);
    test_calm_tail();
    stop_push();
    wait (pending_bytes.size() == 0);
    repeat (20) @(posedge clk);
    if (miss_cnt == 0) begin
      $display("json_string_unescape_core verification clean");
    end else begin
      $display("json_string_unescape_core verification failed");
    end
    $finish;
  end

endmodule
